>>> rtl/core/fvpm_pkg.sv
// ----------------------------------------------------------------------------
// fvpm_pkg
// Shared widths, constants, types and helpers of the flux variation point map.
// ----------------------------------------------------------------------------
package fvpm_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 24;

  localparam int unsigned DW = 33;  // point minus/plus weight
  localparam int unsigned VW = 40;  // vectoring datapath, four guard bits
  localparam int unsigned AW = 36;  // angle, Q2.30 radians with headroom
  localparam int unsigned MW = 37;  // distance, Q.20
  localparam int unsigned RW = 34;  // rotation datapath, Q2.30
  localparam int unsigned QW = 48;  // ratio r2/r1, Q32.16
  localparam int unsigned SW = 32;  // square root, Q16.16

  localparam int unsigned DIV_LAT  = QW + 2;
  localparam int unsigned SQRT_LAT = SW;

  localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [RW-1:0] INVK_Q30    = 34'sd652032874;
  localparam logic [23:0]          INVK_Q24    = 24'd10188014;
  localparam logic [MW-1:0]        ONE_Q20     = 37'd1048576;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001,
    30'h00000000, 30'h00000000
  };

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WEIGHT = 2'd0;
  localparam reg_idx_t REG_SPREAD = 2'd1;

  typedef struct packed {
    logic                 valid;
    logic signed [AW-1:0] ang;
    logic [MW-1:0]        mag;
  } vec_res_t;

  typedef struct packed {
    logic                 valid;
    logic signed [RW-1:0] cos_v;
    logic signed [RW-1:0] sin_v;
  } trig_t;

  function automatic logic signed [AW-1:0] atan_at(logic [4:0] idx);
    return $signed({{(AW-30){1'b0}}, ATAN_TAB[idx]});
  endfunction

  function automatic logic [31:0] sat32(logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/fvpm_dly.sv
// ----------------------------------------------------------------------------
// fvpm_dly
// Fixed delay line; the valid bit is reset, the payload is not.
// ----------------------------------------------------------------------------
module fvpm_dly #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic         v_q [DEPTH];
  logic [W-1:0] d_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < DEPTH; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0] <= data_i;
    for (int i = 1; i < DEPTH; i++) d_q[i] <= d_q[i-1];
  end

  assign valid_o = v_q[DEPTH-1];
  assign data_o  = d_q[DEPTH-1];

endmodule

>>> rtl/core/fvpm_vec.sv
// ----------------------------------------------------------------------------
// fvpm_vec
// Pipelined vectoring CORDIC: angle and gain-corrected length of a vector.
// ----------------------------------------------------------------------------
module fvpm_vec import fvpm_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [31:0]   y_i,
  output vec_res_t             res_o
);

  logic                 v_q    [STAGES+1];
  logic                 zero_q [STAGES+1];
  logic signed [VW-1:0] x_q    [STAGES+1];
  logic signed [VW-1:0] y_q    [STAGES+1];
  logic signed [AW-1:0] z_q    [STAGES+1];

  logic signed [VW-1:0] xs, ys, x_d, y_d;
  logic signed [AW-1:0] z_d;
  logic [VW-1:0]        xc;
  logic [VW+23:0]       prod;
  logic                 res_v_q;
  logic signed [AW-1:0] ang_q;
  logic [MW-1:0]        mag_q;

  // Fold the left half plane onto the right one before the iterations.
  always_comb begin
    xs = VW'(x_i) <<< 4;
    ys = VW'(y_i) <<< 4;
    if (x_i < 0) begin
      x_d = -xs;
      y_d = -ys;
      z_d = (y_i >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      x_d = xs;
      y_d = ys;
      z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= STAGES; i++) v_q[i] <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 0; i < STAGES; i++) v_q[i+1] <= v_q[i];
      res_v_q <= v_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x_d;
    y_q[0]    <= y_d;
    z_q[0]    <= z_d;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    for (int i = 0; i < STAGES; i++) begin
      zero_q[i+1] <= zero_q[i];
      if (!y_q[i][VW-1]) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_at(5'(i));
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_at(5'(i));
      end
    end
  end

  // Remove the CORDIC gain; a negative length clamps to zero.
  always_comb begin
    xc   = x_q[STAGES][VW-1] ? '0 : x_q[STAGES];
    prod = (VW+24)'(xc) * (VW+24)'(INVK_Q24);
  end

  always_ff @(posedge clk_i) begin
    ang_q <= zero_q[STAGES] ? '0 : z_q[STAGES];
    mag_q <= zero_q[STAGES] ? '0 : prod[MW+23:24];
  end

  assign res_o = '{valid: res_v_q, ang: ang_q, mag: mag_q};

endmodule

>>> rtl/core/fvpm_rot.sv
// ----------------------------------------------------------------------------
// fvpm_rot
// Pipelined rotation CORDIC: cosine and sine of a Q2.30 angle.
// ----------------------------------------------------------------------------
module fvpm_rot import fvpm_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [AW-1:0] ang_i,
  output trig_t                res_o
);

  logic                 v_q   [STAGES+1];
  logic                 neg_q [STAGES+1];
  logic signed [RW-1:0] x_q   [STAGES+1];
  logic signed [RW-1:0] y_q   [STAGES+1];
  logic signed [AW-1:0] z_q   [STAGES+1];

  logic signed [AW-1:0] z_d;
  logic                 neg_d;
  logic                 res_v_q;
  logic signed [RW-1:0] cos_q, sin_q;

  // Bring the angle into the right half plane; flip the outputs later.
  always_comb begin
    if (ang_i > HALF_PI_Q30) begin
      z_d   = ang_i - PI_Q30;
      neg_d = 1'b1;
    end else if (ang_i < -HALF_PI_Q30) begin
      z_d   = ang_i + PI_Q30;
      neg_d = 1'b1;
    end else begin
      z_d   = ang_i;
      neg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= STAGES; i++) v_q[i] <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 0; i < STAGES; i++) v_q[i+1] <= v_q[i];
      res_v_q <= v_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= INVK_Q30;
    y_q[0]   <= '0;
    z_q[0]   <= z_d;
    neg_q[0] <= neg_d;
    for (int i = 0; i < STAGES; i++) begin
      neg_q[i+1] <= neg_q[i];
      if (!z_q[i][AW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_at(5'(i));
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_at(5'(i));
      end
    end
    cos_q <= neg_q[STAGES] ? -x_q[STAGES] : x_q[STAGES];
    sin_q <= neg_q[STAGES] ? -y_q[STAGES] : y_q[STAGES];
  end

  assign res_o = '{valid: res_v_q, cos_v: cos_q, sin_v: sin_q};

endmodule

>>> rtl/core/fvpm_div.sv
// ----------------------------------------------------------------------------
// fvpm_div
// Pipelined restoring divider: q = (r2 << 16) / r1, one quotient bit a stage,
// clamped to 48 bits.
// ----------------------------------------------------------------------------
module fvpm_div import fvpm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [MW-1:0] r1_i,
  input  logic [MW-1:0] r2_i,
  output logic          valid_o,
  output logic [QW-1:0] q_o
);

  logic          v_q   [QW+1];
  logic          sat_q [QW+1];
  logic [MW-1:0] d_q   [QW+1];
  logic [MW-1:0] rem_q [QW+1];
  logic [QW-1:0] nq_q  [QW+1];   // numerator bits out, quotient bits in

  logic [MW:0]   t_c   [QW];
  logic          ge_c  [QW];
  logic [MW-1:0] d_d;
  logic [MW-1:0] hi_d;
  logic          v_out_q;
  logic [QW-1:0] q_out_q;

  always_comb begin
    d_d  = (r1_i == '0) ? ONE_Q20 : r1_i;
    hi_d = MW'(r2_i[MW-1:32]);
    for (int i = 0; i < QW; i++) begin
      t_c[i]  = {rem_q[i], nq_q[i][QW-1]};
      ge_c[i] = t_c[i] >= {1'b0, d_q[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QW; i++) v_q[i] <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 0; i < QW; i++) v_q[i+1] <= v_q[i];
      v_out_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0]   <= d_d;
    rem_q[0] <= hi_d;
    sat_q[0] <= hi_d >= d_d;
    nq_q[0]  <= {r2_i[31:0], 16'b0};
    for (int i = 0; i < QW; i++) begin
      d_q[i+1]   <= d_q[i];
      sat_q[i+1] <= sat_q[i];
      rem_q[i+1] <= ge_c[i] ? MW'(t_c[i] - {1'b0, d_q[i]}) : MW'(t_c[i]);
      nq_q[i+1]  <= {nq_q[i][QW-2:0], ge_c[i]};
    end
    q_out_q <= sat_q[QW] ? '1 : nq_q[QW];
  end

  assign valid_o = v_out_q;
  assign q_o     = q_out_q;

endmodule

>>> rtl/core/fvpm_sqrt.sv
// ----------------------------------------------------------------------------
// fvpm_sqrt
// Pipelined integer square root of (q << 16), one root bit a stage.
// ----------------------------------------------------------------------------
module fvpm_sqrt import fvpm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [QW-1:0] q_i,
  output logic          valid_o,
  output logic [SW-1:0] root_o
);

  logic          v_q    [SW];
  logic [SW+1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [QW-1:0] n_q    [SW];

  logic          src_v    [SW];
  logic [SW+1:0] src_rem  [SW];
  logic [SW-1:0] src_root [SW];
  logic [QW-1:0] src_n    [SW];
  logic [SW+3:0] t_c      [SW];
  logic [SW+3:0] trial_c  [SW];
  logic          ge_c     [SW];

  always_comb begin
    src_v[0]    = valid_i;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_n[0]    = q_i;
    for (int i = 1; i < SW; i++) begin
      src_v[i]    = v_q[i-1];
      src_rem[i]  = rem_q[i-1];
      src_root[i] = root_q[i-1];
      src_n[i]    = n_q[i-1];
    end
    for (int i = 0; i < SW; i++) begin
      t_c[i]     = {src_rem[i], src_n[i][QW-1:QW-2]};
      trial_c[i] = (SW+4)'({src_root[i], 2'b01});
      ge_c[i]    = t_c[i] >= trial_c[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SW; i++) v_q[i] <= 1'b0;
    end else begin
      for (int i = 0; i < SW; i++) v_q[i] <= src_v[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SW; i++) begin
      rem_q[i]  <= ge_c[i] ? (SW+2)'(t_c[i] - trial_c[i]) : (SW+2)'(t_c[i]);
      root_q[i] <= {src_root[i][SW-2:0], ge_c[i]};
      n_q[i]    <= {src_n[i][QW-3:0], 2'b00};
    end
  end

  assign valid_o = v_q[SW-1];
  assign root_o  = root_q[SW-1];

endmodule

>>> rtl/core/flux_variation_point_map_core.sv
// ----------------------------------------------------------------------------
// flux_variation_point_map_core
// Flux variation of a fractal flame: maps one Q16.16 point per clock and adds
// the displacement to the running accumulator, saturating each coordinate.
// ----------------------------------------------------------------------------
//
//  channel   signals                               direction  beat taken when
//  --------  ------------------------------------  ---------  ---------------------
//  command   start_i, busy_o, in_*_i, acc_*_i      in         start_i && !busy_o
//  result    done_o, out_x_o, out_y_o, out_z_o     out        done_o (one cycle)
//  config    cfg_valid_i, cfg_ready_o,             in         cfg_valid_i &&
//            cfg_index_i, cfg_data_i                          cfg_ready_o
//
// Cycles: one beat may be taken every clock; busy_o stays low. Each result
//   passes the vectoring CORDIC, the 48-stage divider, the 32-stage root and
//   the multiplier stages that follow before it appears.
// Reset: clears all valid bits; weight returns to 1.0 and spread to 0.
// Stalls: none. The receiver cannot hold results off, so the pipeline always
//   advances and each result is shown for exactly one cycle.
// Config writes are taken in any cycle; write them only while the pipe is
//   empty.
//
module flux_variation_point_map_core import fvpm_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic [31:0] in_z_i,
  input  logic [31:0] acc_x_i,
  input  logic [31:0] acc_y_i,
  input  logic [31:0] acc_z_i,
  output logic        done_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  reg_idx_t    cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Pipeline timing, counted in register stages from the command beat.
  localparam int unsigned VEC_LAT = CORDIC_STAGES + 2;
  localparam int unsigned MID_T   = VEC_LAT + 1;
  localparam int unsigned ROT_LAT = CORDIC_STAGES + 2;
  localparam int unsigned RAD_T   = MID_T + DIV_LAT + SQRT_LAT + 3;
  localparam int unsigned ROT_DLY = RAD_T - (MID_T + ROT_LAT);
  localparam int unsigned OUT_LAT = RAD_T + 3;
  localparam int unsigned SIDE_DLY = OUT_LAT - 1;

  // ---------------------------------------------------------------- config
  logic signed [31:0] weight_q, spread_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= 32'sd65536;
      spread_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WEIGHT: weight_q <= cfg_data_i;
        REG_SPREAD: spread_q <= cfg_data_i;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // ---------------------------------------------------------------- entry
  logic                 accept;
  logic signed [DW-1:0] d1, d2;
  logic [31:0]          zsum;

  assign accept = start_i && !busy_o;

  // Vectors from the two poles at (w,0) and (-w,0).
  always_comb begin
    d1   = $signed({in_x_i[31], in_x_i}) - $signed({weight_q[31], weight_q});
    d2   = $signed({in_x_i[31], in_x_i}) + $signed({weight_q[31], weight_q});
    zsum = sat32(36'($signed(acc_z_i)) + 36'($signed(in_z_i)));
  end

  vec_res_t vec_a, vec_b;

  fvpm_vec #(.STAGES(CORDIC_STAGES)) u_vec_a (
    .clk_i, .rst_ni, .valid_i(accept), .x_i(d1), .y_i($signed(in_y_i)), .res_o(vec_a)
  );

  fvpm_vec #(.STAGES(CORDIC_STAGES)) u_vec_b (
    .clk_i, .rst_ni, .valid_i(accept), .x_i(d2), .y_i($signed(in_y_i)), .res_o(vec_b)
  );

  // Accumulator x/y and the finished z ride alongside the whole pipe.
  logic        side_v;
  logic [95:0] side_q;

  fvpm_dly #(.W(96), .DEPTH(SIDE_DLY)) u_side (
    .clk_i, .rst_ni,
    .valid_i(accept), .data_i({acc_x_i, acc_y_i, zsum}),
    .valid_o(side_v), .data_o(side_q)
  );

  // ---------------------------------------------------------------- mid
  logic                 mid_v_q;
  logic [MW-1:0]        r1_q, r2_q;
  logic signed [AW-1:0] half_q;
  logic signed [AW:0]   adiff;

  assign adiff = (AW+1)'(vec_a.ang) - (AW+1)'(vec_b.ang);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mid_v_q <= 1'b0;
    else         mid_v_q <= vec_a.valid && vec_b.valid;
  end

  always_ff @(posedge clk_i) begin
    r1_q   <= vec_a.mag;
    r2_q   <= vec_b.mag;
    half_q <= AW'(adiff >>> 1);   // floor halving
  end

  // ------------------------------------------------------------ angle path
  trig_t              trig;
  logic               trig_v;
  logic [2*RW-1:0]    trig_dat;
  logic signed [RW-1:0] cos_d, sin_d;

  fvpm_rot #(.STAGES(CORDIC_STAGES)) u_rot (
    .clk_i, .rst_ni, .valid_i(mid_v_q), .ang_i(half_q), .res_o(trig)
  );

  // Hold cos/sin until the radius catches up.
  fvpm_dly #(.W(2*RW), .DEPTH(ROT_DLY)) u_trig_dly (
    .clk_i, .rst_ni,
    .valid_i(trig.valid), .data_i({trig.cos_v, trig.sin_v}),
    .valid_o(trig_v), .data_o(trig_dat)
  );

  assign cos_d = $signed(trig_dat[2*RW-1:RW]);
  assign sin_d = $signed(trig_dat[RW-1:0]);

  // ----------------------------------------------------------- radius path
  logic          div_v, sqrt_v;
  logic [QW-1:0] ratio;
  logic [SW-1:0] root;

  fvpm_div u_div (
    .clk_i, .rst_ni, .valid_i(mid_v_q), .r1_i(r1_q), .r2_i(r2_q),
    .valid_o(div_v), .q_o(ratio)
  );

  fvpm_sqrt u_sqrt (
    .clk_i, .rst_ni, .valid_i(div_v), .q_i(ratio),
    .valid_o(sqrt_v), .root_o(root)
  );

  // u = (spread + 2) * root >> 16, sign and magnitude.
  logic signed [32:0] spr;
  logic               spr_neg;
  logic [31:0]        spr_mag;
  logic [63:0]        uprod;
  logic               um_v_q, um_neg_q;
  logic [47:0]        um_mag_q;

  always_comb begin
    spr     = $signed({spread_q[31], spread_q}) + 33'sd131072;
    spr_neg = spr[32];
    spr_mag = spr_neg ? 32'(-spr) : 32'(spr);
    uprod   = 64'(spr_mag) * 64'(root);
  end

  // radius = w * u >> 16, split into two partial products.
  logic        w_neg;
  logic [31:0] w_mag;
  logic [55:0] pa_lo, pa_hi;
  logic        ra_v_q, ra_neg_q;
  logic [55:0] ra_lo_q, ra_hi_q;

  always_comb begin
    w_neg = weight_q[31];
    w_mag = w_neg ? 32'(-$signed({weight_q[31], weight_q})) : weight_q;
    pa_lo = 56'(w_mag) * 56'(um_mag_q[23:0]);
    pa_hi = 56'(w_mag) * 56'(um_mag_q[47:24]);
  end

  logic [79:0] rprod;
  logic        r_ovf;
  logic [62:0] rmag;
  logic        rb_v_q, rb_neg_q;
  logic [62:0] rb_mag_q;

  always_comb begin
    rprod = {ra_hi_q, 24'b0} + 80'(ra_lo_q);
    r_ovf = rprod[79:64] != '0;
    rmag  = r_ovf ? 63'(1) << 62 : 63'(rprod[63:16]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      um_v_q <= 1'b0;
      ra_v_q <= 1'b0;
      rb_v_q <= 1'b0;
    end else begin
      um_v_q <= sqrt_v;
      ra_v_q <= um_v_q;
      rb_v_q <= ra_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    um_mag_q <= uprod[63:16];
    um_neg_q <= spr_neg && (uprod[63:16] != '0);
    ra_lo_q  <= pa_lo;
    ra_hi_q  <= pa_hi;
    ra_neg_q <= w_neg != um_neg_q;
    rb_mag_q <= rmag;
    rb_neg_q <= ra_neg_q && (rmag != '0);
  end

  // ------------------------------------------------------- term multiplies
  // term = radius * trig >> 30, magnitude clamped to 2^33.
  logic        c_neg, s_neg;
  logic [31:0] c_mag, s_mag;
  logic        ta_v_q, ta_xneg_q, ta_yneg_q;
  logic [63:0] ta_xlo_q, ta_ylo_q;
  logic [62:0] ta_xhi_q, ta_yhi_q;

  always_comb begin
    c_neg = cos_d[RW-1];
    s_neg = sin_d[RW-1];
    c_mag = c_neg ? 32'(-cos_d) : 32'(cos_d);
    s_mag = s_neg ? 32'(-sin_d) : 32'(sin_d);
  end

  logic [64:0]        xsum, ysum;
  logic               x_ovf, y_ovf;
  logic [33:0]        xmag, ymag;
  logic               tb_v_q;
  logic signed [34:0] tb_x_q, tb_y_q;

  always_comb begin
    xsum  = {1'b0, ta_xhi_q[30:0], 33'b0} >> 1;
    xsum  = xsum + 65'(ta_xlo_q);
    ysum  = {1'b0, ta_yhi_q[30:0], 33'b0} >> 1;
    ysum  = ysum + 65'(ta_ylo_q);
    x_ovf = (ta_xhi_q[62:31] != '0) || xsum[64] || xsum[63];
    y_ovf = (ta_yhi_q[62:31] != '0) || ysum[64] || ysum[63];
    xmag  = x_ovf ? 34'(1) << 33 : 34'(xsum[62:30]);
    ymag  = y_ovf ? 34'(1) << 33 : 34'(ysum[62:30]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ta_v_q <= 1'b0;
      tb_v_q <= 1'b0;
    end else begin
      ta_v_q <= rb_v_q;
      tb_v_q <= ta_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ta_xlo_q  <= 64'(rb_mag_q[31:0]) * 64'(c_mag);
    ta_xhi_q  <= 63'(rb_mag_q[62:32]) * 63'(c_mag);
    ta_ylo_q  <= 64'(rb_mag_q[31:0]) * 64'(s_mag);
    ta_yhi_q  <= 63'(rb_mag_q[62:32]) * 63'(s_mag);
    ta_xneg_q <= rb_neg_q != c_neg;
    ta_yneg_q <= rb_neg_q != s_neg;
    tb_x_q    <= ta_xneg_q ? -$signed(35'(xmag)) : $signed(35'(xmag));
    tb_y_q    <= ta_yneg_q ? -$signed(35'(ymag)) : $signed(35'(ymag));
  end

  // ---------------------------------------------------------------- output
  logic        done_q;
  logic [31:0] out_x_q, out_y_q, out_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= tb_v_q;
  end

  always_ff @(posedge clk_i) begin
    out_x_q <= sat32(36'($signed(side_q[95:64])) + 36'(tb_x_q));
    out_y_q <= sat32(36'($signed(side_q[63:32])) + 36'(tb_y_q));
    out_z_q <= side_q[31:0];
  end

  assign done_o  = done_q;
  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign out_z_o = out_z_q;

  // ------------------------------------------------------------ assertions
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##OUT_LAT done_o)
    else $error("result missing after command beat");

  a_trig_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_v == rb_v_q)
    else $error("cos/sin out of step with radius");

  a_side_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_v == tb_v_q)
    else $error("accumulator out of step with terms");

endmodule
